/* rtl/npss_pkg.sv */
`default_nettype none

package npss_pkg;

  // Table size and coordinate width.
  localparam int TABLE_DEPTH = 1024;
  localparam int COORD_BITS  = 16;

  // Fixed field widths of the ports.
  localparam int ACT_W      = 2;
  localparam int PT_W       = 16;
  localparam int STATUS_W   = 3;
  localparam int OUT_IDX_W  = 10;
  localparam int OUT_DIST_W = 33;

  // Derived widths.
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + 1;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                wr_en;
    logic                clr;
    logic                q_start;
    logic                issue;
    logic                out_load;
    logic                out_from_best;
    logic [STATUS_W-1:0] out_code;
  } npss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic scan_last;
    logic pipe_empty;
    logic out_blocked;
  } npss_stat_t;

endpackage

`default_nettype wire

/* rtl/nearest_point_search_2d_top.sv */
`default_nettype none

// Channel   Handshake                 Payload
// in        in_valid / in_stall       in_action, in_point_x, in_point_y
// out       out_valid / out_stall     out_status, out_nearest_index, out_nearest_dist_sq
//
// Load and clear need no scan; their result is registered at the edge of the transfer.
// A query over N stored points reads one table entry per cycle, then
// four pipeline stages (difference, square, sum, compare) drain before the result.
// An empty-table query answers without a scan. Reset empties the table.
// The input stalls during a scan and its drain, and while a finished result waits on out_stall.

module nearest_point_search_2d_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [npss_pkg::ACT_W-1:0]          in_action,
  input  wire logic signed [npss_pkg::PT_W-1:0]    in_point_x,
  input  wire logic signed [npss_pkg::PT_W-1:0]    in_point_y,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [npss_pkg::STATUS_W-1:0]            out_status,
  output logic [npss_pkg::OUT_IDX_W-1:0]           out_nearest_index,
  output logic [npss_pkg::OUT_DIST_W-1:0]          out_nearest_dist_sq
);

  import npss_pkg::*;

  npss_cmd_t  cmd;
  npss_stat_t stat;

  npss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  npss_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_point_x          (in_point_x),
    .in_point_y          (in_point_y),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_nearest_index   (out_nearest_index),
    .out_nearest_dist_sq (out_nearest_dist_sq)
  );

endmodule

`default_nettype wire

/* rtl/npss_ctrl.sv */
`default_nettype none

module npss_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [npss_pkg::ACT_W-1:0] in_action,
  output logic                            in_stall,
  input  wire npss_pkg::npss_stat_t       stat,
  output npss_pkg::npss_cmd_t             cmd
);

  import npss_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE) || stat.out_blocked;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_LOAD: begin
              cmd.wr_en    = !stat.count_full;
              cmd.out_load = 1'b1;
              cmd.out_code = stat.count_full ? ST_FULL : ST_LOADED;
            end
            ACT_QUERY: begin
              if (stat.count_zero) begin
                cmd.out_load = 1'b1;
                cmd.out_code = ST_EMPTY;
              end else begin
                cmd.q_start = 1'b1;
                state_nxt   = S_SCAN;
              end
            end
            ACT_CLEAR: begin
              cmd.clr      = 1'b1;
              cmd.out_load = 1'b1;
              cmd.out_code = ST_CLEARED;
            end
            default: begin
              // The unused action code is dropped without a result.
              cmd = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // Wait until the last distance has been compared and the output is free.
        if (stat.pipe_empty && !stat.out_blocked) begin
          cmd.out_load      = 1'b1;
          cmd.out_from_best = 1'b1;
          cmd.out_code      = ST_FOUND;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/npss_dpath.sv */
`default_nettype none

module npss_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic signed [npss_pkg::PT_W-1:0]     in_point_x,
  input  wire logic signed [npss_pkg::PT_W-1:0]     in_point_y,
  input  wire npss_pkg::npss_cmd_t                  cmd,
  output npss_pkg::npss_stat_t                      stat,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [npss_pkg::STATUS_W-1:0]             out_status,
  output logic [npss_pkg::OUT_IDX_W-1:0]            out_nearest_index,
  output logic [npss_pkg::OUT_DIST_W-1:0]           out_nearest_dist_sq
);

  import npss_pkg::*;

  // Reference point tables.
  coord_t ref_x_mem [TABLE_DEPTH];
  coord_t ref_y_mem [TABLE_DEPTH];

  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] addr_r;
  coord_t           qx_r;
  coord_t           qy_r;
  coord_t           in_x;
  coord_t           in_y;

  // Scan pipeline: read, absolute difference, square, sum, compare.
  logic              v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0]  idx1_r, idx2_r, idx3_r, idx4_r;
  coord_t            rx_r;
  coord_t            ry_r;
  logic [DIFF_W-1:0] adx_r;
  logic [DIFF_W-1:0] ady_r;
  logic [SQ_W-1:0]   sqx_r;
  logic [SQ_W-1:0]   sqy_r;
  logic [DIST_W-1:0] sum_r;

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;

  logic              best_valid_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [DIST_W-1:0] best_dist_r;

  logic [IDX_W+OUT_IDX_W-1:0]   idx_ext;
  logic [DIST_W+OUT_DIST_W-1:0] dist_ext;
  logic [OUT_DIST_W-1:0]        dist_sat;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [OUT_IDX_W-1:0]  out_idx_r;
  logic [OUT_DIST_W-1:0] out_dist_r;

  assign in_x = coord_t'(in_point_x[COORD_BITS-1:0]);
  assign in_y = coord_t'(in_point_y[COORD_BITS-1:0]);

  assign stat.count_zero  = (count_r == '0);
  assign stat.count_full  = (count_r == CNT_W'(TABLE_DEPTH));
  assign stat.scan_last   = ({1'b0, addr_r} == (count_r - CNT_W'(1)));
  assign stat.pipe_empty  = !(v1_r || v2_r || v3_r || v4_r);
  assign stat.out_blocked = out_valid_r && out_stall;

  // Table write on load, registered read during a scan.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      ref_x_mem[count_r[IDX_W-1:0]] <= in_x;
      ref_y_mem[count_r[IDX_W-1:0]] <= in_y;
    end
    if (cmd.issue) begin
      rx_r <= ref_x_mem[addr_r];
      ry_r <= ref_y_mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clr) begin
      count_r <= '0;
    end else if (cmd.wr_en) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      qx_r   <= in_x;
      qy_r   <= in_y;
      addr_r <= '0;
    end else if (cmd.issue) begin
      addr_r <= addr_r + IDX_W'(1);
    end
  end

  assign dx = {qx_r[COORD_BITS-1], qx_r} - {rx_r[COORD_BITS-1], rx_r};
  assign dy = {qy_r[COORD_BITS-1], qy_r} - {ry_r[COORD_BITS-1], ry_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= addr_r;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    adx_r  <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ady_r  <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    sqx_r  <= SQ_W'(adx_r) * SQ_W'(adx_r);
    sqy_r  <= SQ_W'(ady_r) * SQ_W'(ady_r);
    sum_r  <= DIST_W'(sqx_r) + DIST_W'(sqy_r);
  end

  // Only a strictly smaller distance replaces the best, so ties keep the lower index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
    end else if (cmd.q_start) begin
      best_valid_r <= 1'b0;
    end else if (v4_r) begin
      best_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r && (!best_valid_r || (sum_r < best_dist_r))) begin
      best_dist_r <= sum_r;
      best_idx_r  <= idx4_r;
    end
  end

  assign idx_ext  = {OUT_IDX_W'(0), best_idx_r};
  assign dist_ext = {OUT_DIST_W'(0), best_dist_r};
  assign dist_sat = (dist_ext[DIST_W+OUT_DIST_W-1:OUT_DIST_W] != '0) ?
                    {OUT_DIST_W{1'b1}} : dist_ext[OUT_DIST_W-1:0];

  // Output register: a new result may enter in the cycle the old one transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_code;
      out_idx_r    <= cmd.out_from_best ? idx_ext[OUT_IDX_W-1:0] : '0;
      out_dist_r   <= cmd.out_from_best ? dist_sat : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_nearest_index   = out_idx_r;
  assign out_nearest_dist_sq = out_dist_r;

endmodule

`default_nettype wire
